[hdl/imhq_pkg.sv]
// Package for the indexed min-heap queue: action codes and shared types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package imhq_pkg;
  localparam logic [3:0] ACT_INSERT_OR_CHANGE = 4'd0;
  localparam logic [3:0] ACT_INSERT_STORED    = 4'd1;
  localparam logic [3:0] ACT_POP_MIN          = 4'd2;
  localparam logic [3:0] ACT_REMOVE           = 4'd3;
  localparam logic [3:0] ACT_CHANGE_KEY       = 4'd4;
  localparam logic [3:0] ACT_DECREASE_KEY     = 4'd5;
  localparam logic [3:0] ACT_INCREASE_KEY     = 4'd6;
  localparam logic [3:0] ACT_CLEAR            = 4'd7;
  localparam logic [3:0] ACT_QUERY            = 4'd8;
  localparam logic [3:0] ACT_WRITE_KEY        = 4'd9;

  typedef struct packed {
    logic [3:0]         action;
    logic [9:0]         item_index;
    logic signed [31:0] key_value;
  } cmd_t;

  typedef struct packed {
    logic [10:0] result_index;
    logic        found;
    logic        was_in_queue;
    logic [10:0] entry_count;
  } rsp_t;
endpackage
`default_nettype wire

[hdl/imhq_if.sv]
// Valid/ready channel interface carrying one payload item.
// Depends on nothing; the payload type is a parameter.
`timescale 1ns / 1ps
`default_nettype none
interface imhq_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[hdl/imhq_cmp.sv]
// Shared strict signed key compare used by every sift step.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
module imhq_cmp (
  input  wire logic signed [31:0] a,
  input  wire logic signed [31:0] b,
  output logic                    greater
);
  assign greater = a > b;
endmodule
`default_nettype wire

[hdl/indexed_min_heap_queue_unit.sv]
// Indexed min-heap queue over item indices 0..CAPACITY-1, with a stored key per item and a
// slot map that marks each item queued or absent. One action item is taken while cmd.ready
// is high, and the block stays busy until the result is in the output register. Accept,
// lookup and dispatch come first and the output stage last. A sifted action adds a
// write-back step before output. Each sift-up level runs a parent slot read, a parent key
// read and a compare. Each sift-down level runs a child slot read, a child key read, a child
// select and a compare. A sift spans up to log2(CAPACITY) levels, and change and remove can
// sift in both directions. Clear walks the queued entries, reading each heap slot and then
// marking its item absent. After reset a clearing pass marks every item absent before the
// first item is accepted. A result that has not been taken holds the next action in the
// output stage.
`timescale 1ns / 1ps
`default_nettype none
module indexed_min_heap_queue_unit #(
  parameter int CAPACITY = 1024
) (
  input wire logic clk,
  input wire logic rst,
  imhq_if.sink     cmd,
  imhq_if.source   rsp
);
  import imhq_pkg::*;
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = AW + 1;

  typedef enum logic [14:0] {
    S_INIT  = 15'b000000000000001,
    S_IDLE  = 15'b000000000000010,
    S_LOOK  = 15'b000000000000100,
    S_DISP  = 15'b000000000001000,
    S_UPRD  = 15'b000000000010000,
    S_UPKEY = 15'b000000000100000,
    S_UPCMP = 15'b000000001000000,
    S_DNRD  = 15'b000000010000000,
    S_DNKEY = 15'b000000100000000,
    S_DNSEL = 15'b000001000000000,
    S_DNCMP = 15'b000010000000000,
    S_PUT   = 15'b000100000000000,
    S_CLR   = 15'b001000000000000,
    S_CLRW  = 15'b010000000000000,
    S_OUT   = 15'b100000000000000
  } state_t;
  state_t state;

  logic [AW-1:0]        heap_mem [CAPACITY];
  logic [AW:0]          pos_mem  [CAPACITY]; // msb = queued
  logic signed [31:0]   key_mem  [CAPACITY];

  cmd_t          c;
  logic [CW-1:0] count, lim, ci;
  logic [AW-1:0] slot, item, mover, c1it, c2it;
  logic signed [31:0] key, k1, k2, krd;
  logic          do_down, has2;
  logic [AW-1:0] hrd, pos_q;
  logic          pos_v;
  logic [AW-1:0] last_it;
  logic [1:0]    sub;
  logic [10:0]   res_index;
  logic          res_found, res_was;
  logic          gt;
  logic signed [31:0] ca, cb;

  imhq_cmp u_cmp (.a(ca), .b(cb), .greater(gt));

  always_comb begin
    unique case (state)
      S_DNSEL: begin ca = k1; cb = k2; end
      S_DNCMP: begin ca = key; cb = krd; end
      default: begin ca = krd; cb = key; end
    endcase
  end

  wire in_range = {1'b0, c.item_index} < CW'(CAPACITY);
  assign cmd.ready = (state == S_IDLE);
  wire [AW-1:0] cidx = AW'(c.item_index);
  wire [CW-1:0] child = {slot, 1'b1};
  wire [AW-1:0] parent = (slot - 1'b1) >> 1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT; ci <= '0; count <= '0; rsp.valid <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready && state != S_OUT) rsp.valid <= 1'b0;
      unique case (state)
        S_INIT: begin
          pos_mem[AW'(ci)] <= '0; ci <= ci + 1'b1;
          if (ci == CW'(CAPACITY - 1)) state <= S_IDLE;
        end
        S_IDLE: if (cmd.valid) begin
          c <= cmd.data; state <= S_LOOK;
        end
        S_LOOK: begin
          {pos_v, pos_q} <= pos_mem[cidx];
          hrd <= heap_mem[AW'(count - 1'b1)];
          last_it <= heap_mem['0];
          sub <= '0; state <= S_DISP;
        end
        S_DISP: begin
          res_was   <= in_range && pos_v;
          res_found <= c.action == ACT_POP_MIN && count != '0;
          res_index <= (c.action != ACT_POP_MIN) ? 11'd0 :
                       (count == '0) ? 11'(CAPACITY) : 11'(last_it);
          priority if (!in_range && c.action != ACT_POP_MIN && c.action != ACT_CLEAR) begin
            state <= S_OUT;
          end else if (c.action == ACT_POP_MIN) begin
            if (count == '0) state <= S_OUT;
            else begin
              pos_mem[last_it] <= '0;
              count <= count - 1'b1;
              if (count == CW'(1)) state <= S_OUT;
              else begin
                lim <= count - 1'b1; item <= hrd; key <= key_mem[hrd];
                slot <= '0; state <= S_DNRD;
              end
            end
          end else if (c.action == ACT_CLEAR) begin
            ci <= '0; state <= S_CLR;
          end else if ((c.action == ACT_INSERT_OR_CHANGE || c.action == ACT_INSERT_STORED)
                       && !pos_v) begin
            if (c.action == ACT_INSERT_OR_CHANGE) begin
              key_mem[cidx] <= c.key_value; key <= c.key_value;
            end else key <= key_mem[cidx];
            item <= cidx; slot <= AW'(count); do_down <= 1'b0;
            count <= count + 1'b1; state <= S_UPRD;
          end else if (pos_v && (c.action == ACT_INSERT_OR_CHANGE ||
                                 c.action == ACT_CHANGE_KEY ||
                                 c.action == ACT_DECREASE_KEY ||
                                 c.action == ACT_INCREASE_KEY)) begin
            key_mem[cidx] <= c.key_value; key <= c.key_value;
            item <= cidx; slot <= pos_q; lim <= count;
            do_down <= c.action != ACT_DECREASE_KEY;
            state <= (c.action == ACT_INCREASE_KEY) ? S_DNRD : S_UPRD;
          end else if (c.action == ACT_WRITE_KEY) begin
            key_mem[cidx] <= c.key_value; state <= S_OUT;
          end else if (c.action == ACT_REMOVE && pos_v) begin
            pos_mem[cidx] <= '0;
            count <= count - 1'b1;
            if ({1'b0, pos_q} == count - 1'b1) state <= S_OUT;
            else begin
              lim <= count - 1'b1; item <= hrd; key <= key_mem[hrd];
              slot <= pos_q; do_down <= 1'b1; state <= S_UPRD;
            end
          end else state <= S_OUT;
        end
        S_UPRD: begin
          if (slot == '0) state <= do_down ? S_DNRD : S_PUT;
          else begin
            hrd <= heap_mem[parent];
            state <= S_UPKEY;
          end
        end
        S_UPKEY: begin
          krd <= key_mem[hrd]; state <= S_UPCMP;
        end
        S_UPCMP: begin
          if (gt) begin
            heap_mem[slot] <= hrd; pos_mem[hrd] <= {1'b1, slot};
            slot <= parent; state <= S_UPRD;
          end else state <= do_down ? S_DNRD : S_PUT;
        end
        S_DNRD: begin
          if (child >= lim) state <= S_PUT;
          else begin
            has2 <= (child + 1'b1) < lim;
            c1it <= heap_mem[AW'(child)];
            c2it <= heap_mem[AW'(child + 1'b1)];
            state <= S_DNKEY;
          end
        end
        S_DNKEY: begin
          k1 <= key_mem[c1it]; k2 <= key_mem[c2it];
          state <= S_DNSEL;
        end
        S_DNSEL: begin
          // take the right child only when it is strictly smaller
          if (has2 && gt) begin
            krd <= k2; mover <= c2it; sub <= 2'd2;
          end else begin
            krd <= k1; mover <= c1it; sub <= 2'd1;
          end
          state <= S_DNCMP;
        end
        S_DNCMP: begin
          if (gt) begin
            heap_mem[slot] <= mover; pos_mem[mover] <= {1'b1, slot};
            slot <= AW'({slot, 1'b0} + CW'(sub)); state <= S_DNRD;
          end else state <= S_PUT;
        end
        S_PUT: begin
          heap_mem[slot] <= item; pos_mem[item] <= {1'b1, slot}; state <= S_OUT;
        end
        S_CLR: begin
          if (ci >= count) begin count <= '0; state <= S_OUT; end
          else begin
            hrd <= heap_mem[AW'(ci)]; state <= S_CLRW;
          end
        end
        S_CLRW: begin
          pos_mem[hrd] <= '0; ci <= ci + 1'b1; state <= S_CLR;
        end
        S_OUT: if (!rsp.valid || rsp.ready) begin
          rsp.valid <= 1'b1;
          rsp.data.result_index <= res_index;
          rsp.data.found <= res_found;
          rsp.data.was_in_queue <= res_was;
          rsp.data.entry_count <= 11'(count);
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
